/* hw/rtl/tns_pkg.sv */
// Package for the tone note sequencer: sizes, register reset values,
// configuration register indexes and the controller/datapath interface structs.
// No dependencies; every other file of the block imports it.
package tns_pkg;

    // Note queue geometry.
    localparam int NOTE_DEPTH = 32;
    localparam int PTR_W      = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(NOTE_DEPTH + 1);

    // Field widths.
    localparam int PITCH_W    = 8;
    localparam int UNITS_W    = 8;
    localparam int NOTE_W     = PITCH_W + 2 * UNITS_W;
    localparam int QUEUED_W   = 6;
    localparam int PERIOD_W   = 16;
    localparam int STEP_W     = 8;
    localparam int DSTEP_W    = 16;
    localparam int PRESCALE_W = 16;
    localparam int DUR_W      = UNITS_W + DSTEP_W;

    // Stream and configuration port widths.
    localparam int S_TDATA_W  = NOTE_W;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Register reset values.
    localparam logic [PERIOD_W-1:0]   MIN_PERIOD_RST   = 16'd1600;
    localparam logic [STEP_W-1:0]     PERIOD_STEP_RST  = 8'd9;
    localparam logic [DSTEP_W-1:0]    DUR_STEP_RST     = 16'd1562;
    localparam logic [PRESCALE_W-1:0] DUR_PRESCALE_RST = 16'd1024;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_STEP  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUR_STEP     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUR_PRESCALE = 8'd3;

    // Input item kind carried in s_tuser.
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_ADD  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // latch the accepted input transaction
        logic do_add;      // store the note if the queue has room
        logic rd_head;     // read the note at the queue head
        logic mul;         // form the period and tone duration products
        logic load_note;   // start the note and pop the queue
        logic tick;        // advance the timers by one base tick
        logic sil_load;    // load the silence duration
        logic load_out;    // capture the result into the output register
    } tns_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic phase_idle;
        logic queue_empty;
        logic sil_start;
    } tns_status_t;

endpackage

/* hw/rtl/tns_note_fifo.sv */
// Note queue: a first-in first-out memory of packed notes with head/tail
// pointers, a fill count and a registered read port. Depends on tns_pkg.
module tns_note_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [tns_pkg::NOTE_W-1:0]  wr_data,
    input  logic                        rd_en,
    output logic [tns_pkg::NOTE_W-1:0]  rd_data,
    input  logic                        pop,
    output logic [tns_pkg::CNT_W-1:0]   count,
    output logic                        full,
    output logic                        empty
);
    import tns_pkg::*;

    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(NOTE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(NOTE_DEPTH);

    logic [NOTE_W-1:0] mem [NOTE_DEPTH];
    logic [NOTE_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // Pointer wrap and fill count update.
    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (wr_en) begin
            tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
        end
        if (pop) begin
            head_next = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
        end
        if (wr_en && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Storage with one write port and a registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[tail_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[head_reg];
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;
    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);

endmodule

/* hw/rtl/tns_datapath.sv */
// Datapath of the tone note sequencer: configuration registers, note queue,
// tone and duration timers, pin level and the result register.
// Depends on tns_pkg and tns_note_fifo.
module tns_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  tns_pkg::tns_cmd_t               cmd,
    output tns_pkg::tns_status_t            status,
    input  logic [tns_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            cfg_wr,
    input  logic [tns_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tns_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [tns_pkg::M_TDATA_W-1:0]   out_data
);
    import tns_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TONE,
        PH_SILENCE
    } phase_t;

    localparam logic [PERIOD_W:0] PERIOD_MAX = {1'b0, {PERIOD_W{1'b1}}};

    // Configuration registers.
    logic [PERIOD_W-1:0]   min_period_reg;
    logic [STEP_W-1:0]     period_step_reg;
    logic [DSTEP_W-1:0]    dur_step_reg;
    logic [PRESCALE_W-1:0] dur_prescale_reg;

    // Item, product and timer registers.
    logic [NOTE_W-1:0]     item_reg;
    logic                  acc_reg;
    logic [PERIOD_W-1:0]   hp_prod_reg;
    logic [DUR_W-1:0]      dur_prod_reg;
    phase_t                phase_reg;
    logic [PERIOD_W-1:0]   half_period_reg;
    logic [PERIOD_W-1:0]   pitch_cnt_reg;
    logic [PRESCALE_W-1:0] prescale_cnt_reg;
    logic [DUR_W-1:0]      dur_cnt_reg;
    logic [UNITS_W-1:0]    pending_reg;
    logic                  pin_reg;
    logic [M_TDATA_W-1:0]  out_data_reg;

    // Queue signals.
    logic [NOTE_W-1:0] head_note;
    logic [CNT_W-1:0]  queue_count;
    logic              queue_full;
    logic              queue_empty;
    logic              fifo_wr;

    // Timer step signals.
    logic [PERIOD_W:0]     hp_sum;
    logic [PERIOD_W-1:0]   hp_sat;
    logic [PERIOD_W:0]     pitch_inc;
    logic                  toggle;
    logic [PRESCALE_W-1:0] prescale_eff;
    logic [PRESCALE_W:0]   prescale_inc;
    logic                  prescale_wrap;
    logic                  dur_end;
    logic                  sil_start;
    logic                  busy;

    assign fifo_wr = cmd.do_add && !queue_full;

    tns_note_fifo u_note_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (fifo_wr),
        .wr_data (item_reg),
        .rd_en   (cmd.rd_head),
        .rd_data (head_note),
        .pop     (cmd.load_note),
        .count   (queue_count),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_period_reg   <= MIN_PERIOD_RST;
            period_step_reg  <= PERIOD_STEP_RST;
            dur_step_reg     <= DUR_STEP_RST;
            dur_prescale_reg <= DUR_PRESCALE_RST;
        end else if (cfg_wr) begin
            case (cfg_index)
                CFG_MIN_PERIOD:   min_period_reg   <= cfg_data[PERIOD_W-1:0];
                CFG_PERIOD_STEP:  period_step_reg  <= cfg_data[STEP_W-1:0];
                CFG_DUR_STEP:     dur_step_reg     <= cfg_data[DSTEP_W-1:0];
                CFG_DUR_PRESCALE: dur_prescale_reg <= cfg_data[PRESCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Half period with saturation, and one base tick of the timers.
    always_comb begin
        hp_sum        = {1'b0, min_period_reg} + {1'b0, hp_prod_reg} + 1'b1;
        hp_sat        = (hp_sum > PERIOD_MAX) ? PERIOD_MAX[PERIOD_W-1:0]
                                              : hp_sum[PERIOD_W-1:0];
        pitch_inc     = {1'b0, pitch_cnt_reg} + 1'b1;
        toggle        = (phase_reg == PH_TONE) && (pitch_inc >= {1'b0, half_period_reg});
        prescale_eff  = (dur_prescale_reg == '0) ? PRESCALE_W'(1) : dur_prescale_reg;
        prescale_inc  = {1'b0, prescale_cnt_reg} + 1'b1;
        prescale_wrap = (prescale_inc >= {1'b0, prescale_eff});
        dur_end       = prescale_wrap && (dur_cnt_reg == '0);
        sil_start     = dur_end && (phase_reg == PH_TONE) && (pending_reg != '0);
        busy          = (phase_reg != PH_IDLE);
    end

    // Item latch, accept flag and multiplier stage.
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_tdata;
            acc_reg  <= 1'b0;
        end
        if (cmd.do_add) begin
            acc_reg <= !queue_full;
        end
        if (cmd.mul) begin
            hp_prod_reg  <= period_step_reg * head_note[PITCH_W-1:0];
            dur_prod_reg <= head_note[PITCH_W +: UNITS_W] * dur_step_reg;
        end
    end

    // Note timers and pin level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            half_period_reg  <= '0;
            pitch_cnt_reg    <= '0;
            prescale_cnt_reg <= '0;
            dur_cnt_reg      <= '0;
            pending_reg      <= '0;
            pin_reg          <= 1'b0;
        end else begin
            if (cmd.load_note) begin
                half_period_reg  <= hp_sat;
                dur_cnt_reg      <= dur_prod_reg;
                pending_reg      <= head_note[PITCH_W+UNITS_W +: UNITS_W];
                pitch_cnt_reg    <= '0;
                prescale_cnt_reg <= '0;
                phase_reg        <= PH_TONE;
            end
            if (cmd.tick) begin
                if (dur_end) begin
                    // The phase is over: the pin goes low even if a toggle was due.
                    pin_reg       <= 1'b0;
                    pitch_cnt_reg <= '0;
                    if (sil_start) begin
                        phase_reg <= PH_SILENCE;
                    end else begin
                        pending_reg <= '0;
                        phase_reg   <= PH_IDLE;
                    end
                end else if (phase_reg == PH_TONE) begin
                    pitch_cnt_reg <= toggle ? '0 : pitch_inc[PERIOD_W-1:0];
                    if (toggle) begin
                        pin_reg <= !pin_reg;
                    end
                end
                if (!prescale_wrap) begin
                    prescale_cnt_reg <= prescale_inc[PRESCALE_W-1:0];
                end else begin
                    prescale_cnt_reg <= '0;
                    if (dur_cnt_reg != '0) begin
                        dur_cnt_reg <= dur_cnt_reg - 1'b1;
                    end
                end
            end
            if (cmd.sil_load) begin
                dur_cnt_reg <= pending_reg * dur_step_reg;
                pending_reg <= '0;
            end
        end
    end

    // Result register: pin, busy, accepted, queued notes from the low bit up.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_data_reg <= M_TDATA_W'({QUEUED_W'(queue_count), acc_reg, busy, pin_reg});
        end
    end

    assign out_data           = out_data_reg;
    assign status.phase_idle  = !busy;
    assign status.queue_empty = queue_empty;
    assign status.sil_start   = sil_start;

endmodule

/* hw/rtl/tns_ctrl.sv */
// Controller of the tone note sequencer: sequences each input transaction
// through the datapath and owns both stream handshakes. Depends on tns_pkg.
module tns_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 item_mode,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  tns_pkg::tns_status_t status,
    output tns_pkg::tns_cmd_t    cmd
);
    import tns_pkg::*;

    typedef enum logic [2:0] {
        S_IN,
        S_ADD,
        S_RD,
        S_MUL,
        S_LOAD,
        S_TICK,
        S_SIL,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   in_fire;
    logic   out_free;

    assign in_fire  = (state_reg == S_IN) && s_tvalid;
    assign out_free = !m_tvalid_reg || m_tready;

    // Commands decoded from the current state.
    always_comb begin
        cmd           = '0;
        cmd.load_item = in_fire;
        cmd.do_add    = (state_reg == S_ADD);
        cmd.rd_head   = (state_reg == S_RD);
        cmd.mul       = (state_reg == S_MUL);
        cmd.load_note = (state_reg == S_LOAD);
        cmd.tick      = (state_reg == S_TICK);
        cmd.sil_load  = (state_reg == S_SIL);
        cmd.load_out  = (state_reg == S_OUT) && out_free;
    end

    // Next state and output valid.
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IN: begin
                if (s_tvalid) begin
                    if (item_mode == MODE_ADD) begin
                        state_next = S_ADD;
                    end else if (!status.phase_idle) begin
                        state_next = S_TICK;
                    end else if (!status.queue_empty) begin
                        state_next = S_RD;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_ADD:  state_next = S_OUT;
            S_RD:   state_next = S_MUL;
            S_MUL:  state_next = S_LOAD;
            S_LOAD: state_next = S_OUT;
            S_TICK: state_next = status.sil_start ? S_SIL : S_OUT;
            S_SIL:  state_next = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IN;
                end
            end
            default: state_next = S_IN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IN;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == S_IN);
    assign m_tvalid = m_tvalid_reg;

endmodule

/* hw/rtl/tone_note_sequencer.sv */
// Tone note sequencer: square-wave buzzer driver fed from a queue of notes.
// Input stream: s_tuser selects the item kind (0 = one base tick, 1 = add a
// note); s_tdata carries the note (pitch code, tone units, silence units).
// Every input transaction yields exactly one result transaction on m_tdata:
// pin level, busy flag, accepted flag and the number of queued notes.
// An add stores the note whole when the queue has room, otherwise it is
// refused. A tick advances the tone and duration timers; a tick in idle with
// a note queued starts that note.
// The result is registered in state S_OUT, reached directly for a tick that
// finds nothing to play, via S_ADD for an add, S_TICK for a playing tick,
// S_TICK and S_SIL when a tone turns into a silence, and S_RD (queue read),
// S_MUL and S_LOAD when a note starts; the next item is taken after S_OUT.
// The result register holds while m_tready is low; the next item is then
// processed up to the point where it waits for that register to free up.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always taken and
// must be made only while the block is idle.
// Reset (aresetn low, synchronous) empties the queue, stops any note, drives
// the pin low and restores the register defaults.
// Depends on tns_pkg, tns_ctrl, tns_datapath and tns_note_fifo.
module tone_note_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: pitch_code[7:0], tone_units[15:8], silence_units[23:16].
    input  logic [tns_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: mode[0].
    input  logic [tns_pkg::S_TUSER_W-1:0]   s_tuser,
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: buzzer_level[0], busy_res[1], accepted[2], queued_notes[8:3], zero[15:9].
    output logic [tns_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tns_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tns_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tns_pkg::*;

    tns_cmd_t    cmd;
    tns_status_t status;
    logic        cfg_wr;

    // Register writes complete in the cycle they are presented.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    tns_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .item_mode (s_tuser[0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    tns_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_wr    (cfg_wr),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata)
    );

endmodule
